FILE: rtl/som_gnd_pkg.sv
// Shared constants, payload types and helper functions for the SOM grid distance unit.
// Used by every module under rtl; depends on nothing else.
package som_gnd_pkg;

   // Map size and register limits.
   localparam int GRID_SIZE = 256;
   localparam int SPAN_MAX  = 511;
   localparam int DIST_MAX  = 1023;

   // Field and port widths.
   localparam int COORD_W      = 8;
   localparam int SPAN_W       = 9;
   localparam int TOPO_W       = 2;
   localparam int CSR_ADDR_W   = 2;
   localparam int DIST_W       = 10;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 16;

   // Internal arithmetic widths.
   localparam int WRAP_W       = 9;   // wrapped axis difference, -255..255
   localparam int ALT_W        = 11;  // lo + span - hi
   localparam int SQ_W         = 16;  // square of one axis difference
   localparam int RAD_W        = 18;  // radicand, padded to whole bit pairs
   localparam int ROOT_W       = 9;   // integer root
   localparam int REM_W        = 11;  // root remainder
   localparam int ROOT_STEPS   = 3;   // root bits resolved per stage
   localparam int ROOT_STAGES  = ROOT_W / ROOT_STEPS;
   localparam int TORUS_W      = 10;  // coordinate after moving down by a span
   localparam int HEX_PT_W     = 11;  // x - y/2 and axis differences
   localparam int HEX_D_W      = 13;  // hex dx and dx + dy
   localparam int HEX_ABS_W    = 12;  // magnitude of a hex difference
   localparam int HEX_CANDS    = 4;   // candidate placements on the hex torus

   // Topology codes.
   localparam logic [TOPO_W-1:0] TOPO_SQUARE_TORUS = 2'd0;
   localparam logic [TOPO_W-1:0] TOPO_HEX_PLAIN    = 2'd1;
   localparam logic [TOPO_W-1:0] TOPO_HEX_TORUS    = 2'd2;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_TOPOLOGY     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_ROWS    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_COLUMNS = 2'd2;

   localparam logic [SPAN_W-1:0] SPAN_RESET =
      SPAN_W'(GRID_SIZE > SPAN_MAX ? SPAN_MAX : GRID_SIZE);

   // Output of the coordinate preparation stage.
   typedef struct packed {
      logic [WRAP_W-1:0]                    sq_dx;
      logic [WRAP_W-1:0]                    sq_dy;
      logic [HEX_CANDS-1:0][HEX_PT_W-1:0]   u_first;
      logic [HEX_CANDS-1:0][HEX_PT_W-1:0]   u_second;
      logic [1:0][HEX_PT_W-1:0]             dy;
   } prep_type;

   // Output of the metric stage.
   typedef struct packed {
      logic [SQ_W-1:0]                      sq_x;
      logic [SQ_W-1:0]                      sq_y;
      logic [HEX_CANDS-1:0][HEX_ABS_W-1:0]  hex_max;
   } metric_type;

   // Working state of the square root pipeline, with the hex result riding along.
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [DIST_W-1:0] hex_dist;
   } root_stage_type;

   // Halve a signed value, rounding toward zero.
   function automatic logic signed [TORUS_W-1:0] half_toward_zero(
      input logic signed [TORUS_W-1:0] v);
      return (v >>> 1) + $signed({{(TORUS_W-1){1'b0}}, v[TORUS_W-1] & v[0]});
   endfunction

   // Magnitude of a hex difference.
   function automatic logic [HEX_ABS_W-1:0] hex_abs(input logic signed [HEX_D_W-1:0] v);
      logic [HEX_D_W-1:0] mag;
      mag = v[HEX_D_W-1] ? -v : v;
      return mag[HEX_ABS_W-1:0];
   endfunction

endpackage

FILE: rtl/som_gnd_prep.sv
// First pipeline stage: wrapped axis differences for the square torus and
// shifted hex coordinates for all four hex torus placements. Uses som_gnd_pkg.
module som_gnd_prep (
   input  logic                           clock,
   input  logic                           load,
   input  logic [som_gnd_pkg::COORD_W-1:0] first_x,
   input  logic [som_gnd_pkg::COORD_W-1:0] first_y,
   input  logic [som_gnd_pkg::COORD_W-1:0] second_x,
   input  logic [som_gnd_pkg::COORD_W-1:0] second_y,
   input  logic [som_gnd_pkg::SPAN_W-1:0]  grid_rows,
   input  logic [som_gnd_pkg::SPAN_W-1:0]  grid_columns,
   output som_gnd_pkg::prep_type           prep_q
);
   import som_gnd_pkg::*;

   prep_type prep_in;
   prep_type prep_ff;

   // Smaller of the direct and the wrapped difference along one axis.
   function automatic logic [WRAP_W-1:0] wrap_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [SPAN_W-1:0]  span);
      logic [COORD_W-1:0]      hi;
      logic [COORD_W-1:0]      lo;
      logic [COORD_W-1:0]      diff;
      logic signed [ALT_W-1:0] alt;
      hi   = (a > b) ? a : b;
      lo   = (a > b) ? b : a;
      diff = hi - lo;
      alt  = $signed({3'b000, lo}) + $signed({2'b00, span}) - $signed({3'b000, hi});
      if (alt < $signed({3'b000, diff})) begin
         return alt[WRAP_W-1:0];
      end
      return {1'b0, diff};
   endfunction

   // Coordinates, moved down by a span on the point the hex torus selects.
   logic signed [TORUS_W-1:0] x1_s, x2_s, y1_s, y2_s;
   logic signed [TORUS_W-1:0] x1_w, x2_w, y1_w, y2_w;
   logic signed [TORUS_W-1:0] rows_s, cols_s;
   logic signed [TORUS_W-1:0] xa, xb, ya, yb, ha, hb;

   always_comb begin
      x1_s   = $signed({2'b00, first_x});
      x2_s   = $signed({2'b00, second_x});
      y1_s   = $signed({2'b00, first_y});
      y2_s   = $signed({2'b00, second_y});
      rows_s = $signed({1'b0, grid_rows});
      cols_s = $signed({1'b0, grid_columns});

      if (first_x < second_x) begin
         x1_w = x1_s;
         x2_w = x2_s - rows_s;
      end else begin
         x1_w = x1_s - rows_s;
         x2_w = x2_s;
      end
      if (first_y < second_y) begin
         y1_w = y1_s;
         y2_w = y2_s - cols_s;
      end else begin
         y1_w = y1_s - cols_s;
         y2_w = y2_s;
      end

      prep_in.sq_dx = wrap_diff(first_x, second_x, grid_rows);
      prep_in.sq_dy = wrap_diff(first_y, second_y, grid_columns);

      // Placement k moves x when bit 0 is set and y when bit 1 is set.
      xa = x1_s;
      xb = x2_s;
      ya = y1_s;
      yb = y2_s;
      ha = '0;
      hb = '0;
      for (int k = 0; k < HEX_CANDS; k++) begin
         xa = k[0] ? x1_w : x1_s;
         xb = k[0] ? x2_w : x2_s;
         ya = k[1] ? y1_w : y1_s;
         yb = k[1] ? y2_w : y2_s;
         ha = half_toward_zero(ya);
         hb = half_toward_zero(yb);
         prep_in.u_first[k]  = $signed({xa[TORUS_W-1], xa}) - $signed({ha[TORUS_W-1], ha});
         prep_in.u_second[k] = $signed({xb[TORUS_W-1], xb}) - $signed({hb[TORUS_W-1], hb});
      end

      prep_in.dy[0] = $signed({y2_s[TORUS_W-1], y2_s}) - $signed({y1_s[TORUS_W-1], y1_s});
      prep_in.dy[1] = $signed({y2_w[TORUS_W-1], y2_w}) - $signed({y1_w[TORUS_W-1], y1_w});
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (load) begin
         prep_ff <= prep_in;
      end
   end

   assign prep_q = prep_ff;

endmodule

FILE: rtl/som_gnd_metric.sv
// Second pipeline stage: squares of the wrapped differences and the hex
// distance of each torus placement. Uses som_gnd_pkg.
module som_gnd_metric (
   input  logic                    clock,
   input  logic                    load,
   input  som_gnd_pkg::prep_type   prep_d,
   output som_gnd_pkg::metric_type metric_q
);
   import som_gnd_pkg::*;

   metric_type metric_in;
   metric_type metric_ff;

   logic signed [2*WRAP_W-1:0]  prod_x;
   logic signed [2*WRAP_W-1:0]  prod_y;
   logic signed [HEX_D_W-1:0]   dx;
   logic signed [HEX_D_W-1:0]   dy;
   logic signed [HEX_D_W-1:0]   dsum;
   logic [HEX_ABS_W-1:0]        a_dx, a_dy, a_sum, m;
   logic [HEX_PT_W-1:0]         u1, u2, dy_raw;

   always_comb begin
      // Squares of values below 256 in magnitude fit sixteen bits.
      prod_x = $signed(prep_d.sq_dx) * $signed(prep_d.sq_dx);
      prod_y = $signed(prep_d.sq_dy) * $signed(prep_d.sq_dy);
      metric_in.sq_x = prod_x[SQ_W-1:0];
      metric_in.sq_y = prod_y[SQ_W-1:0];

      // Hex distance: the largest of |dx|, |dy| and |dx + dy|.
      u1 = '0;
      u2 = '0;
      dy_raw = '0;
      dx = '0;
      dy = '0;
      dsum = '0;
      a_dx = '0;
      a_dy = '0;
      a_sum = '0;
      m = '0;
      for (int k = 0; k < HEX_CANDS; k++) begin
         u1     = prep_d.u_first[k];
         u2     = prep_d.u_second[k];
         dy_raw = prep_d.dy[k[1]];
         dx     = $signed({{2{u2[HEX_PT_W-1]}}, u2}) - $signed({{2{u1[HEX_PT_W-1]}}, u1});
         dy     = $signed({{2{dy_raw[HEX_PT_W-1]}}, dy_raw});
         dsum   = dx + dy;
         a_dx   = hex_abs(dx);
         a_dy   = hex_abs(dy);
         a_sum  = hex_abs(dsum);
         m      = (a_dy > a_dx) ? a_dy : a_dx;
         m      = (a_sum > m) ? a_sum : m;
         metric_in.hex_max[k] = m;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (load) begin
         metric_ff <= metric_in;
      end
   end

   assign metric_q = metric_ff;

endmodule

FILE: rtl/som_gnd_reduce.sv
// Third pipeline stage: sum of squares as the radicand and the hex result
// chosen by topology, saturated to the output range. Uses som_gnd_pkg.
module som_gnd_reduce (
   input  logic                               clock,
   input  logic                               load,
   input  logic [som_gnd_pkg::TOPO_W-1:0]     topology,
   input  som_gnd_pkg::metric_type            metric_d,
   output som_gnd_pkg::root_stage_type        reduce_q
);
   import som_gnd_pkg::*;

   root_stage_type reduce_in;
   root_stage_type reduce_ff;

   logic [SQ_W:0]          sq_sum;
   logic [HEX_ABS_W-1:0]   min_lo, min_hi, min_all, hex_sel;

   always_comb begin
      sq_sum = {1'b0, metric_d.sq_x} + {1'b0, metric_d.sq_y};

      // Least of the four placements; the plain grid uses the unmoved one only.
      min_lo  = (metric_d.hex_max[1] < metric_d.hex_max[0]) ?
                metric_d.hex_max[1] : metric_d.hex_max[0];
      min_hi  = (metric_d.hex_max[3] < metric_d.hex_max[2]) ?
                metric_d.hex_max[3] : metric_d.hex_max[2];
      min_all = (min_hi < min_lo) ? min_hi : min_lo;
      hex_sel = (topology == TOPO_HEX_PLAIN) ? metric_d.hex_max[0] : min_all;

      reduce_in.rad      = {{(RAD_W-SQ_W-1){1'b0}}, sq_sum};
      reduce_in.rem      = '0;
      reduce_in.root     = '0;
      reduce_in.hex_dist = (hex_sel > HEX_ABS_W'(DIST_MAX)) ?
                           DIST_W'(DIST_MAX) : hex_sel[DIST_W-1:0];
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (load) begin
         reduce_ff <= reduce_in;
      end
   end

   assign reduce_q = reduce_ff;

endmodule

FILE: rtl/som_gnd_root_stage.sv
// One stage of the digit-by-digit integer square root: resolves ROOT_STEPS root
// bits each time it loads and passes the hex result along. Uses som_gnd_pkg.
module som_gnd_root_stage (
   input  logic                         clock,
   input  logic                         load,
   input  som_gnd_pkg::root_stage_type  root_d,
   output som_gnd_pkg::root_stage_type  root_q
);
   import som_gnd_pkg::*;

   root_stage_type root_in;
   root_stage_type root_ff;

   logic [REM_W+1:0] rem_ext;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] rem_sub;

   // Each step brings down the next bit pair and tries the next root bit.
   always_comb begin
      root_in = root_d;
      rem_ext = '0;
      trial   = '0;
      rem_sub = '0;
      for (int i = 0; i < ROOT_STEPS; i++) begin
         rem_ext = {root_in.rem, root_in.rad[RAD_W-1 -: 2]};
         trial   = {2'b00, root_in.root, 2'b01};
         rem_sub = rem_ext - trial;
         if (rem_ext >= trial) begin
            root_in.rem  = rem_sub[REM_W-1:0];
            root_in.root = {root_in.root[ROOT_W-2:0], 1'b1};
         end else begin
            root_in.rem  = rem_ext[REM_W-1:0];
            root_in.root = {root_in.root[ROOT_W-2:0], 1'b0};
         end
         root_in.rad = {root_in.rad[RAD_W-3:0], 2'b00};
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (load) begin
         root_ff <= root_in;
      end
   end

   assign root_q = root_ff;

endmodule

FILE: rtl/som_grid_neuron_distance.sv
// The edge that accepts a request loads the first of seven register stages (prep, metric,
// reduce, three square root stages, output). Throughput: one request per cycle unless all
// stages are full and the result is stalled; each stage holds its item only while the next
// stage is full and stalled, so empty stages are filled behind a waiting result.
// Reset (synchronous, active high) empties the pipeline and sets topology to square
// torus and both spans to the grid size.
module som_grid_neuron_distance (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata: first_x [7:0], first_y [15:8], second_x [23:16], second_y [31:24]
   input  logic [som_gnd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: grid_distance [9:0], zero above
   output logic [som_gnd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Register write port.
   input  logic                                 csr_wr_en,
   input  logic [som_gnd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [som_gnd_pkg::SPAN_W-1:0]       csr_wr_data
);
   import som_gnd_pkg::*;

   localparam int STAGES  = ROOT_STAGES + 4;
   localparam int OUT_STG = STAGES - 1;

   // Configuration registers.
   logic [TOPO_W-1:0] topology_ff, topology_in;
   logic [SPAN_W-1:0] grid_rows_ff, grid_rows_in;
   logic [SPAN_W-1:0] grid_columns_ff, grid_columns_in;

   always_comb begin
      topology_in     = topology_ff;
      grid_rows_in    = grid_rows_ff;
      grid_columns_in = grid_columns_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            REG_TOPOLOGY:     topology_in     = csr_wr_data[TOPO_W-1:0];
            REG_GRID_ROWS:    grid_rows_in    = csr_wr_data;
            REG_GRID_COLUMNS: grid_columns_in = csr_wr_data;
            default:          topology_in     = topology_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff     <= TOPO_SQUARE_TORUS;
         grid_rows_ff    <= SPAN_RESET;
         grid_columns_ff <= SPAN_RESET;
      end else begin
         topology_ff     <= topology_in;
         grid_rows_ff    <= grid_rows_in;
         grid_columns_ff <= grid_columns_in;
      end
   end

   // Valid bits and per-stage advance: a stage loads when empty or when it drains.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] advance;

   always_comb begin
      advance[OUT_STG] = !valid_ff[OUT_STG] || rsp_tready;
      for (int k = OUT_STG - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k + 1];
      end
      valid_in[0] = advance[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = advance[0];
   assign rsp_tvalid = valid_ff[OUT_STG];

   // Datapath stages.
   prep_type       prep_q;
   metric_type     metric_q;
   root_stage_type root_q [ROOT_STAGES+1];

   som_gnd_prep u_prep (
      .clock        (clock),
      .load         (advance[0]),
      .first_x      (req_tdata[COORD_W-1:0]),
      .first_y      (req_tdata[2*COORD_W-1:COORD_W]),
      .second_x     (req_tdata[3*COORD_W-1:2*COORD_W]),
      .second_y     (req_tdata[4*COORD_W-1:3*COORD_W]),
      .grid_rows    (grid_rows_ff),
      .grid_columns (grid_columns_ff),
      .prep_q       (prep_q)
   );

   som_gnd_metric u_metric (
      .clock    (clock),
      .load     (advance[1]),
      .prep_d   (prep_q),
      .metric_q (metric_q)
   );

   som_gnd_reduce u_reduce (
      .clock    (clock),
      .load     (advance[2]),
      .topology (topology_ff),
      .metric_d (metric_q),
      .reduce_q (root_q[0])
   );

   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
      som_gnd_root_stage u_root (
         .clock  (clock),
         .load   (advance[g + 3]),
         .root_d (root_q[g]),
         .root_q (root_q[g + 1])
      );
   end

   // Output register: pick the root or the hex result.
   logic [DIST_W-1:0] dist_ff, dist_in;

   always_comb begin
      if (topology_ff == TOPO_SQUARE_TORUS) begin
         dist_in = {{(DIST_W-ROOT_W){1'b0}}, root_q[ROOT_STAGES].root};
      end else begin
         dist_in = root_q[ROOT_STAGES].hex_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[OUT_STG]) begin
         dist_ff <= dist_in;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-DIST_W){1'b0}}, dist_ff};

`ifndef SYNTHESIS
   // An accepted request always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // Without traffic on either side the number of items in flight does not change.
   a_items_kept: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)
      |=> $countones(valid_ff) == $past($countones(valid_ff)))
      else $error("pipeline lost or invented an item");

   // A full pipeline behind a stalled result takes no request.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("request accepted into a full stalled pipeline");

   // With the result side ready, the request side is never blocked.
   a_ready_flows: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("pipeline stalled while the result side was ready");
`endif

endmodule
